// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the cache modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// shared constants and types of the lfu cache
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int CAP_W      = 5;
    localparam int CAP_RESET  = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W     = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_W-1:0]    last_use;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } lfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } lfu_stat_t;

endpackage

// ----- src/lfu_ram.sv -----
// ----------------------------------------------------------------------------
// lfu_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfu_ctrl
// sequencer: accept, scan all entries, then commit the update
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lfu_pkg::lfu_stat_t stat,
    output lfu_pkg::lfu_cmd_t  cmd
);
    import lfu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // hold while the previous result is still unread
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `LFU_ASSERT(a_scan_ends, (state_reg == ST_SCAN) && stat.scan_last |=> state_reg == ST_UPDATE, "scan did not end in update")
    `LFU_ASSERT(a_commit_free, cmd.commit |-> stat.out_free, "commit over unread result")

endmodule

// ----- src/lfu_dp.sv -----
// ----------------------------------------------------------------------------
// lfu_dp
// entry store, scan accumulators, update logic and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata,
    input  lfu_pkg::req_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lfu_pkg::rsp_t                     m_data,
    input  lfu_pkg::lfu_cmd_t                 cmd,
    output lfu_pkg::lfu_stat_t                stat
);
    import lfu_pkg::*;

    logic [CAP_W-1:0]   cap_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    req_t               item_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [USED_W-1:0]  used_reg;

    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [VAL_W-1:0]      hit_val_reg;
    logic [COUNT_BITS-1:0] hit_cnt_reg;

    logic                  free_ok_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    logic                  vic_ok_reg;
    logic [IDX_W-1:0]      vic_idx_reg;
    logic [KEY_W-1:0]      vic_key_reg;
    logic [COUNT_BITS-1:0] vic_cnt_reg;
    logic [STAMP_W-1:0]    vic_lu_reg;

    logic out_valid_reg;
    rsp_t out_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           rec;

    logic cur_valid;
    logic cur_match;
    logic cur_better;

    logic [USED_W-1:0]     cap_eff;
    logic                  is_put;
    logic                  cap_nz;
    logic                  do_touch;
    logic                  do_ins;
    logic                  do_evict;
    logic                  ins_ok;
    logic [IDX_W-1:0]      ins_idx;
    logic [COUNT_BITS-1:0] cnt_inc;
    rsp_t                  rsp;

    lfu_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rec)
    );

    // entry 0 is read while idle, so it is ready on the first scan cycle
    assign ram_raddr = cmd.scan ? IDX_W'(cnt_reg + IDX_W'(1)) : '0;

    assign cur_valid  = valid_reg[cnt_reg];
    assign cur_match  = cur_valid && (rec.key == item_reg.key);
    assign cur_better = cur_valid &&
                        (!vic_ok_reg || (rec.count < vic_cnt_reg) ||
                         ((rec.count == vic_cnt_reg) && (rec.last_use < vic_lu_reg)));

    assign stat.scan_last = (cnt_reg == IDX_W'(ENTRIES - 1));
    assign stat.out_free  = !out_valid_reg || m_ready;

    always_comb begin
        cap_eff  = (32'(cap_reg) > ENTRIES) ? USED_W'(ENTRIES) : USED_W'(cap_reg);
        is_put   = (item_reg.mode == MODE_PUT);
        cap_nz   = (cap_eff != '0);
        do_touch = hit_reg && (!is_put || cap_nz);
        do_ins   = is_put && cap_nz && !hit_reg;
        do_evict = do_ins && (used_reg >= cap_eff) && vic_ok_reg;
        // the freed victim slot counts as free when it is the lowest one
        if (do_evict && (!free_ok_reg || (vic_idx_reg < free_idx_reg))) begin
            ins_idx = vic_idx_reg;
        end else begin
            ins_idx = free_idx_reg;
        end
        ins_ok  = do_evict || free_ok_reg;
        cnt_inc = (hit_cnt_reg == {COUNT_BITS{1'b1}}) ? hit_cnt_reg
                                                      : hit_cnt_reg + COUNT_BITS'(1);

        // victim leaves first, the insert may land in the same slot
        valid_next = valid_reg;
        if (do_evict) begin
            valid_next[vic_idx_reg] = 1'b0;
        end
        if (do_ins && ins_ok) begin
            valid_next[ins_idx] = 1'b1;
        end

        ram_we    = cmd.commit && (do_touch || (do_ins && ins_ok));
        ram_waddr = do_touch ? hit_idx_reg : ins_idx;
        ram_wdata.key      = item_reg.key;
        ram_wdata.last_use = clock_reg;
        if (do_touch) begin
            ram_wdata.value = is_put ? item_reg.value : hit_val_reg;
            ram_wdata.count = cnt_inc;
        end else begin
            ram_wdata.value = item_reg.value;
            ram_wdata.count = '0;
        end

        rsp.hit         = hit_reg;
        rsp.read_value  = (!is_put && hit_reg) ? hit_val_reg : '0;
        rsp.evicted     = do_evict;
        rsp.evicted_key = do_evict ? vic_key_reg : '0;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_W'(CAP_RESET);
            clock_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
                if (clock_reg != {STAMP_W{1'b1}}) begin
                    clock_reg <= clock_reg + STAMP_W'(1);
                end
                valid_reg <= valid_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan accumulators and payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_reg    <= s_data;
            cnt_reg     <= '0;
            used_reg    <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
            vic_ok_reg  <= 1'b0;
        end else if (cmd.scan) begin
            cnt_reg  <= IDX_W'(cnt_reg + IDX_W'(1));
            used_reg <= used_reg + USED_W'(cur_valid);
            if (cur_match && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cnt_reg;
                hit_val_reg <= rec.value;
                hit_cnt_reg <= rec.count;
            end
            if (!cur_valid && !free_ok_reg) begin
                free_ok_reg  <= 1'b1;
                free_idx_reg <= cnt_reg;
            end
            if (cur_better) begin
                vic_ok_reg  <= 1'b1;
                vic_idx_reg <= cnt_reg;
                vic_key_reg <= rec.key;
                vic_cnt_reg <= rec.count;
                vic_lu_reg  <= rec.last_use;
            end
        end
        if (cmd.commit) begin
            out_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `LFU_ASSERT(a_commit_shows, cmd.commit |=> out_valid_reg, "committed result not shown")
    `LFU_ASSERT(a_fill_monotonic, 1'b1 |=> $countones(valid_reg) >= $past($countones(valid_reg)), "entry count dropped")
    `LFU_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.start, cmd.scan, cmd.commit}), "overlapping commands")

endmodule

// ----- src/lfu_cache_with_lru_tiebreak.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak
// 16-entry key-value cache, least-frequently-used replacement, lru tie-break
//   s_ channel: one beat per access (mode get or put, key, value)
//   m_ channel: one result beat per access (hit, read value, evicted key)
//   cfg_we / cfg_wdata: capacity register, write only while the cache is idle
// each access is accepted in the idle state, then a scan walks the
// entry ram one entry per cycle (key match, fill count, lowest free slot and
// victim search), and an update state writes the ram and loads the result
// the next beat is taken as soon as the update is done, while the result may
// still wait in the output register; a stalled receiver holds the next
// access in its update cycle until the register is read
// reset empties the cache (valid bits cleared at once), zeroes the access
// clock and sets capacity to 16; entry ram contents need no clearing
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lfu_pkg::req_t             s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lfu_pkg::rsp_t             m_data
);
    import lfu_pkg::*;

    lfu_cmd_t  cmd;
    lfu_stat_t stat;

    // sequencer: idle, scan, update
    lfu_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // entry store, search accumulators and result register
    lfu_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
